// ===== rtl/pdsc_pkg.sv =====
// Shared types and constants for the datagram deframer and checksum checker.
package pdsc_pkg;

  localparam int HdrBytes         = 12;
  localparam int FrameOverhead    = 14;
  localparam int MaxDatagramDflt  = 65535;
  localparam int QueueDepth       = 4;
  localparam logic [15:0] MinSizeReset = 16'd14;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;
  localparam logic [1:0] STATUS_CSUM_BAD = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  version;
    logic [7:0]  message_type;
    logic [15:0] message_id;
    logic [31:0] token;
    logic [31:0] payload_length;
    logic [15:0] received_checksum;
    logic [15:0] computed_sum;
    logic [1:0]  status;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== rtl/pdsc_frame.sv =====
// Per-byte datagram state: header capture, byte sum, checksum capture and verdict.
module pdsc_frame #(
  parameter int MAX_DATAGRAM_BYTES = pdsc_pkg::MaxDatagramDflt
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [15:0]     cfg_data,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            end_of_datagram,
  output pdsc_pkg::push_t push
);
  import pdsc_pkg::*;

  localparam logic [15:0] CountLimit =
    (MAX_DATAGRAM_BYTES < 65535) ? 16'(MAX_DATAGRAM_BYTES) : 16'hFFFF;

  logic [15:0] min_packet_size;
  logic [15:0] byte_count;
  logic        count_overflow;
  logic [7:0]  header_store [HdrBytes];
  logic [15:0] running_sum;
  logic [15:0] checksum_store;

  logic [15:0] byte_count_next;
  logic        count_overflow_next;
  logic [7:0]  header_store_next [HdrBytes];
  logic [15:0] running_sum_next;
  logic [15:0] checksum_store_next;

  logic [32:0] plen_cur;
  logic [32:0] payload_end;
  logic [32:0] p_ext;
  logic [31:0] plen_new;
  logic [32:0] frame_total;
  logic        is_payload;
  logic [1:0]  status;
  result_t     payload_res;
  result_t     verdict_res;

  always_comb begin
    byte_count_next     = byte_count;
    count_overflow_next = count_overflow;
    header_store_next   = header_store;
    running_sum_next    = running_sum;
    checksum_store_next = checksum_store;
    is_payload          = 1'b0;
    plen_cur    = {1'b0, header_store[8], header_store[9], header_store[10], header_store[11]};
    payload_end = plen_cur + 33'(HdrBytes);
    p_ext       = {17'd0, byte_count};
    if (byte_count >= CountLimit) begin
      count_overflow_next = 1'b1;
    end else begin
      byte_count_next = byte_count + 16'd1;
      if (byte_count < 16'(HdrBytes)) begin
        header_store_next[byte_count[3:0]] = data_byte;
        running_sum_next = running_sum + {8'd0, data_byte};
      end else if (p_ext < payload_end) begin
        running_sum_next = running_sum + {8'd0, data_byte};
        is_payload = 1'b1;
      end else if (p_ext == payload_end) begin
        checksum_store_next = {data_byte, checksum_store[7:0]};
      end else if (p_ext == payload_end + 33'd1) begin
        checksum_store_next = {checksum_store[15:8], data_byte};
      end
    end
  end

  always_comb begin
    plen_new = {header_store_next[8], header_store_next[9],
                header_store_next[10], header_store_next[11]};
    frame_total = {1'b0, plen_new} + 33'(FrameOverhead);
    if (count_overflow_next) begin
      status = STATUS_MISMATCH;
    end else if (byte_count_next < min_packet_size) begin
      status = STATUS_SHORT;
    end else if ({17'd0, byte_count_next} != frame_total) begin
      status = STATUS_MISMATCH;
    end else if (running_sum_next != checksum_store_next) begin
      status = STATUS_CSUM_BAD;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    payload_res              = '0;
    payload_res.kind         = KIND_PAYLOAD;
    payload_res.payload_byte = data_byte;
    payload_res.run_last     = !end_of_datagram;

    verdict_res                   = '0;
    verdict_res.kind              = KIND_VERDICT;
    verdict_res.version           = header_store_next[0];
    verdict_res.message_type      = header_store_next[1];
    verdict_res.message_id        = {header_store_next[2], header_store_next[3]};
    verdict_res.token             = {header_store_next[4], header_store_next[5],
                                     header_store_next[6], header_store_next[7]};
    verdict_res.payload_length    = plen_new;
    verdict_res.received_checksum = checksum_store_next;
    verdict_res.computed_sum      = running_sum_next;
    verdict_res.status            = status;
    verdict_res.run_last          = 1'b1;

    push.second = verdict_res;
    if (!fire) begin
      push.n     = 2'd0;
      push.first = payload_res;
    end else if (is_payload) begin
      push.n     = end_of_datagram ? 2'd2 : 2'd1;
      push.first = payload_res;
    end else begin
      push.n     = end_of_datagram ? 2'd1 : 2'd0;
      push.first = verdict_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_packet_size <= MinSizeReset;
    end else if (cfg_write) begin
      min_packet_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && end_of_datagram)) begin
      byte_count     <= '0;
      count_overflow <= 1'b0;
      for (int i = 0; i < HdrBytes; i++) begin
        header_store[i] <= '0;
      end
      running_sum    <= '0;
      checksum_store <= '0;
    end else if (fire) begin
      byte_count     <= byte_count_next;
      count_overflow <= count_overflow_next;
      header_store   <= header_store_next;
      running_sum    <= running_sum_next;
      checksum_store <= checksum_store_next;
    end
  end

endmodule

// ===== rtl/pdsc_outq.sv =====
// Result queue: takes up to two result beats per cycle, hands out one per cycle while out_ready is high.
module pdsc_outq (
  input  logic              clk,
  input  logic              rst,
  input  pdsc_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output pdsc_pkg::result_t head
);
  import pdsc_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  result_t         entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= CntW'(QueueDepth - 2));
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr + PtrW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push.n) - CntW'(pop);
    end
  end

endmodule

// ===== rtl/packet_deframer_sum16_check.sv =====
// Top level of the datagram deframer with 16-bit byte-sum check.
// Takes one datagram byte per beat and can accept a beat every cycle while
// the queue has room. Each beat is captured in an input register and processed
// once the queue has room for its results, which are written into a four-entry
// result queue and offered at the output. A payload byte yields one result beat;
// the final byte of a datagram adds a verdict beat, so a payload byte that ends a
// datagram yields two. The queue drains one beat per cycle while out_ready is
// high, and the input stalls only while the queue lacks room for two more beats.
// min_packet_size resets to 14 and may be rewritten through cfg_write/cfg_data
// while the block is idle.
module packet_deframer_sum16_check #(
  parameter int MAX_DATAGRAM_BYTES = pdsc_pkg::MaxDatagramDflt
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_datagram,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  version,
  output logic [7:0]  message_type,
  output logic [15:0] message_id,
  output logic [31:0] token,
  output logic [31:0] payload_length,
  output logic [15:0] received_checksum,
  output logic [15:0] computed_sum,
  output logic [1:0]  status,
  output logic        run_last
);
  import pdsc_pkg::*;

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_eod;
  logic       room;
  logic       fire;
  push_t      push;
  result_t    head;

  assign fire     = in_reg_valid && room;
  assign in_ready = !in_reg_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_byte <= data_byte;
      in_reg_eod  <= end_of_datagram;
    end
  end

  pdsc_frame #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_frame (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .fire           (fire),
    .data_byte      (in_reg_byte),
    .end_of_datagram(in_reg_eod),
    .push           (push)
  );

  pdsc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign kind              = head.kind;
  assign payload_byte      = head.payload_byte;
  assign version           = head.version;
  assign message_type      = head.message_type;
  assign message_id        = head.message_id;
  assign token             = head.token;
  assign payload_length    = head.payload_length;
  assign received_checksum = head.received_checksum;
  assign computed_sum      = head.computed_sum;
  assign status            = head.status;
  assign run_last          = head.run_last;

endmodule
